FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMFE_ASSERT_IMP(lbl, c, r, a, b, m) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
        else $error(m);

// Next-cycle implication, disabled while reset is asserted.
`define LMFE_ASSERT_NXT(lbl, c, r, a, b, m) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
        else $error(m);

`endif

FILE: hw/rtl/lmfe_pkg.sv
// ----------------------------------------------------------------------------
// lmfe_pkg
// Constants for the location message field encoder and its checker.
// ----------------------------------------------------------------------------
package lmfe_pkg;

    // direction
    localparam logic [16:0] DIR_ROUND       = 17'd8;
    localparam logic [11:0] DIR_RECIP       = 12'd2913;   // ceil(2^20 / 360)
    localparam logic [12:0] DIR_FULL        = 13'd360;
    localparam logic [8:0]  DIR_HALF        = 9'd180;
    localparam logic [7:0]  DIR_CODE_MAX    = 8'd179;

    // horizontal speed
    localparam logic [15:0] SPD_KNEE        = 16'd1020;
    localparam logic [14:0] SPD_RECIP       = 15'd21846;  // ceil(2^16 / 3)
    localparam logic [12:0] SPD_CODE_LIMIT  = 13'd255;
    localparam logic [7:0]  SPD_CODE_MAX    = 8'd255;

    // vertical speed
    localparam logic signed [16:0] VS_ROUND = 17'sd7;
    localparam logic signed [16:0] VS_HI    = 17'sd127;
    localparam logic signed [16:0] VS_LO    = -17'sd128;
    localparam logic [7:0]  VS_CODE_HI      = 8'h7F;
    localparam logic [7:0]  VS_CODE_LO      = 8'h80;

    // latitude / longitude
    localparam logic [23:0] LATLON_SCALE    = 24'd10000000;
    localparam logic [32:0] LATLON_LIMIT    = 33'd1800000000;
    localparam logic [30:0] LATLON_MAX      = 31'd1800000000;

    // altitude
    localparam logic signed [21:0] ALT_OFFSET = 22'sd16000;
    localparam logic [15:0] ALT_CODE_MAX    = 16'hFFFF;

    // time
    localparam logic [19:0] TIME_ROUND      = 20'd8;
    localparam logic [15:0] TIME_CODE_MAX   = 16'd36000;

endpackage

FILE: hw/rtl/location_message_field_encoder_core.sv
// ----------------------------------------------------------------------------
// location_message_field_encoder_core
// Throughput: 1 report/cycle while out_stall is low.
// Four register stages (decode, multiply, clamp, sign/output) with valid bits;
// each stage advances when it is empty or the next one moves.
// Reset (async, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module location_message_field_encoder_core
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        direction_deg,
    input  logic [15:0]        speed_horizontal,
    input  logic signed [15:0] speed_vertical,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [20:0] altitude_baro,
    input  logic signed [20:0] altitude_geo,
    input  logic signed [20:0] height_above,
    input  logic [15:0]        timestamp,
    input  logic [7:0]         status_code,
    input  logic               height_reference,
    input  logic [39:0]        accuracy_codes,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               fail,
    output logic [7:0]         direction_code,
    output logic [1:0]         flags,
    output logic [7:0]         speed_code,
    output logic signed [7:0]  vspeed_code,
    output logic signed [31:0] lat_code,
    output logic signed [31:0] lon_code,
    output logic [15:0]        alt_baro_code,
    output logic [15:0]        alt_geo_code,
    output logic [15:0]        height_code,
    output logic [15:0]        time_code,
    output logic [24:0]        passthrough_nibbles
);
    import lmfe_pkg::*;

    typedef struct packed {
        logic               fail;
        logic [12:0]        dir;
        logic               mult;
        logic [13:0]        spd_x;
        logic [7:0]         spd_lo;
        logic [7:0]         vs;
        logic               lat_neg;
        logic [31:0]        lat_mag;
        logic               lon_neg;
        logic [31:0]        lon_mag;
        logic signed [21:0] alt_b;
        logic signed [21:0] alt_g;
        logic signed [21:0] alt_h;
        logic [15:0]        tim;
        logic [24:0]        pass;
    } s1_t;

    typedef struct packed {
        logic               fail;
        logic [12:0]        dir;
        logic [3:0]         dir_q;
        logic               mult;
        logic [12:0]        spd_q;
        logic [7:0]         spd_lo;
        logic [7:0]         vs;
        logic               lat_neg;
        logic [32:0]        lat_q;
        logic               lon_neg;
        logic [32:0]        lon_q;
        logic signed [21:0] alt_b;
        logic signed [21:0] alt_g;
        logic signed [21:0] alt_h;
        logic [15:0]        tim;
        logic [24:0]        pass;
    } s2_t;

    typedef struct packed {
        logic               fail;
        logic [7:0]         dir_code;
        logic [1:0]         flags;
        logic [7:0]         spd_code;
        logic [7:0]         vs;
        logic               lat_neg;
        logic [30:0]        lat_mag;
        logic               lon_neg;
        logic [30:0]        lon_mag;
        logic [15:0]        alt_b;
        logic [15:0]        alt_g;
        logic [15:0]        alt_h;
        logic [15:0]        tim;
        logic [24:0]        pass;
    } s3_t;

    typedef struct packed {
        logic               fail;
        logic [7:0]         dir_code;
        logic [1:0]         flags;
        logic [7:0]         spd_code;
        logic [7:0]         vs;
        logic [31:0]        lat;
        logic [31:0]        lon;
        logic [15:0]        alt_b;
        logic [15:0]        alt_g;
        logic [15:0]        alt_h;
        logic [15:0]        tim;
        logic [24:0]        pass;
    } s4_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;

    // flow control
    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= s1_next;
        if (rdy2)
            s2_reg <= s2_next;
        if (rdy3)
            s3_reg <= s3_next;
        if (rdy4)
            s4_reg <= s4_next;
    end

    // stage 1: decode, offsets, magnitudes
    logic [16:0]        dir_sum;
    logic [15:0]        spd_diff;
    logic signed [16:0] vs_adj;
    logic signed [16:0] vs_div;
    logic [19:0]        tim_sum;

    assign dir_sum  = {1'b0, direction_deg} + DIR_ROUND;
    assign spd_diff = speed_horizontal - SPD_KNEE;
    assign vs_adj   = {speed_vertical[15], speed_vertical}
                    + (speed_vertical[15] ? VS_ROUND : 17'sd0);
    assign vs_div   = vs_adj >>> 3;
    assign tim_sum  = {1'b0, timestamp, 3'b000} + {3'b000, timestamp, 1'b0} + TIME_ROUND;

    always_comb
    begin
        s1_next.fail = |status_code[7:4];
        for (int i = 0; i < 5; i++)
            s1_next.fail = s1_next.fail | (|accuracy_codes[8*i+4 +: 4]);
        s1_next.dir    = dir_sum[16:4];
        s1_next.mult   = speed_horizontal > SPD_KNEE;
        s1_next.spd_x  = spd_diff[15:2];
        s1_next.spd_lo = speed_horizontal[9:2];
        if (vs_div > VS_HI)
            s1_next.vs = VS_CODE_HI;
        else if (vs_div < VS_LO)
            s1_next.vs = VS_CODE_LO;
        else
            s1_next.vs = vs_div[7:0];
        s1_next.lat_neg = latitude[31];
        s1_next.lat_mag = latitude[31] ? (~latitude + 32'd1) : latitude;
        s1_next.lon_neg = longitude[31];
        s1_next.lon_mag = longitude[31] ? (~longitude + 32'd1) : longitude;
        s1_next.alt_b   = {altitude_baro[20], altitude_baro} + ALT_OFFSET;
        s1_next.alt_g   = {altitude_geo[20], altitude_geo} + ALT_OFFSET;
        s1_next.alt_h   = {height_above[20], height_above} + ALT_OFFSET;
        s1_next.tim     = tim_sum[19:4];
        s1_next.pass    = {accuracy_codes[35:32], accuracy_codes[27:24],
                           accuracy_codes[19:16], accuracy_codes[11:8],
                           accuracy_codes[3:0], height_reference, status_code[3:0]};
    end

    // stage 2: constant multiplies
    logic [24:0] dir_prod;
    logic [28:0] spd_prod;
    logic [55:0] lat_prod;
    logic [55:0] lon_prod;

    assign dir_prod = {12'd0, s1_reg.dir} * {13'd0, DIR_RECIP};
    assign spd_prod = {15'd0, s1_reg.spd_x} * {14'd0, SPD_RECIP};
    assign lat_prod = {24'd0, s1_reg.lat_mag} * {32'd0, LATLON_SCALE};
    assign lon_prod = {24'd0, s1_reg.lon_mag} * {32'd0, LATLON_SCALE};

    always_comb
    begin
        s2_next.fail    = s1_reg.fail;
        s2_next.dir     = s1_reg.dir;
        s2_next.dir_q   = dir_prod[23:20];
        s2_next.mult    = s1_reg.mult;
        s2_next.spd_q   = spd_prod[28:16];
        s2_next.spd_lo  = s1_reg.spd_lo;
        s2_next.vs      = s1_reg.vs;
        s2_next.lat_neg = s1_reg.lat_neg;
        s2_next.lat_q   = lat_prod[55:23];
        s2_next.lon_neg = s1_reg.lon_neg;
        s2_next.lon_q   = lon_prod[55:23];
        s2_next.alt_b   = s1_reg.alt_b;
        s2_next.alt_g   = s1_reg.alt_g;
        s2_next.alt_h   = s1_reg.alt_h;
        s2_next.tim     = s1_reg.tim;
        s2_next.pass    = s1_reg.pass;
    end

    // stage 3: remainders, folding, clamps
    logic [12:0] dir_q360;
    logic [12:0] dir_rem;
    logic [8:0]  dir_r;
    logic        west;

    assign dir_q360 = {9'd0, s2_reg.dir_q} * DIR_FULL;
    assign dir_rem  = s2_reg.dir - dir_q360;
    assign dir_r    = dir_rem[8:0];
    assign west     = dir_r >= DIR_HALF;

    function automatic logic [15:0] alt_clamp(input logic signed [21:0] sum);
        logic [15:0] res;
        if (sum[21])
            res = 16'd0;
        else if (|sum[20:19])
            res = ALT_CODE_MAX;
        else
            res = sum[18:3];
        return res;
    endfunction

    always_comb
    begin
        logic [8:0] folded;
        folded           = west ? (dir_r - DIR_HALF) : dir_r;
        s3_next.fail     = s2_reg.fail;
        s3_next.dir_code = folded[7:0];
        s3_next.flags    = {s2_reg.mult, west};
        if (!s2_reg.mult)
            s3_next.spd_code = s2_reg.spd_lo;
        else if (s2_reg.spd_q > SPD_CODE_LIMIT)
            s3_next.spd_code = SPD_CODE_MAX;
        else
            s3_next.spd_code = s2_reg.spd_q[7:0];
        s3_next.vs      = s2_reg.vs;
        s3_next.lat_neg = s2_reg.lat_neg;
        s3_next.lat_mag = (s2_reg.lat_q > LATLON_LIMIT) ? LATLON_MAX : s2_reg.lat_q[30:0];
        s3_next.lon_neg = s2_reg.lon_neg;
        s3_next.lon_mag = (s2_reg.lon_q > LATLON_LIMIT) ? LATLON_MAX : s2_reg.lon_q[30:0];
        s3_next.alt_b   = alt_clamp(s2_reg.alt_b);
        s3_next.alt_g   = alt_clamp(s2_reg.alt_g);
        s3_next.alt_h   = alt_clamp(s2_reg.alt_h);
        s3_next.tim     = (s2_reg.tim > TIME_CODE_MAX) ? TIME_CODE_MAX : s2_reg.tim;
        s3_next.pass    = s2_reg.pass;
    end

    // stage 4: restore sign, blank on fail
    always_comb
    begin
        logic [31:0] lat_pos;
        logic [31:0] lon_pos;
        lat_pos = {1'b0, s3_reg.lat_mag};
        lon_pos = {1'b0, s3_reg.lon_mag};
        s4_next.fail     = s3_reg.fail;
        s4_next.dir_code = s3_reg.dir_code;
        s4_next.flags    = s3_reg.flags;
        s4_next.spd_code = s3_reg.spd_code;
        s4_next.vs       = s3_reg.vs;
        s4_next.lat      = s3_reg.lat_neg ? (32'd0 - lat_pos) : lat_pos;
        s4_next.lon      = s3_reg.lon_neg ? (32'd0 - lon_pos) : lon_pos;
        s4_next.alt_b    = s3_reg.alt_b;
        s4_next.alt_g    = s3_reg.alt_g;
        s4_next.alt_h    = s3_reg.alt_h;
        s4_next.tim      = s3_reg.tim;
        s4_next.pass     = s3_reg.pass;
        if (s3_reg.fail)
        begin
            s4_next      = '0;
            s4_next.fail = 1'b1;
        end
    end

    assign out_valid           = v4_reg;
    assign fail                = s4_reg.fail;
    assign direction_code      = s4_reg.dir_code;
    assign flags               = s4_reg.flags;
    assign speed_code          = s4_reg.spd_code;
    assign vspeed_code         = s4_reg.vs;
    assign lat_code            = s4_reg.lat;
    assign lon_code            = s4_reg.lon;
    assign alt_baro_code       = s4_reg.alt_b;
    assign alt_geo_code        = s4_reg.alt_g;
    assign height_code         = s4_reg.alt_h;
    assign time_code           = s4_reg.tim;
    assign passthrough_nibbles = s4_reg.pass;

endmodule

FILE: hw/rtl/lmfe_checker.sv
// ----------------------------------------------------------------------------
// lmfe_checker
// Port-level checks on the location message field encoder results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmfe_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               fail,
    input logic [7:0]         direction_code,
    input logic [1:0]         flags,
    input logic [7:0]         speed_code,
    input logic signed [7:0]  vspeed_code,
    input logic signed [31:0] lat_code,
    input logic signed [31:0] lon_code,
    input logic [15:0]        alt_baro_code,
    input logic [15:0]        alt_geo_code,
    input logic [15:0]        height_code,
    input logic [15:0]        time_code,
    input logic [24:0]        passthrough_nibbles
);
    import lmfe_pkg::*;

    logic        fields_zero;
    logic        out_hold;
    logic [47:0] held;

    assign fields_zero = (direction_code == '0) && (flags == '0) && (speed_code == '0)
                      && (vspeed_code == '0) && (lat_code == '0) && (lon_code == '0)
                      && (alt_baro_code == '0) && (alt_geo_code == '0)
                      && (height_code == '0) && (time_code == '0)
                      && (passthrough_nibbles == '0);
    assign out_hold = out_valid && out_stall;
    assign held     = {lat_code, time_code};

    `LMFE_ASSERT_IMP(a_fail_blank, clk, rst_n, out_valid && fail, fields_zero, "fail not blank")
    `LMFE_ASSERT_IMP(a_dir_range, clk, rst_n, out_valid, direction_code <= DIR_CODE_MAX, "dir range")
    `LMFE_ASSERT_IMP(a_time_range, clk, rst_n, out_valid, time_code <= TIME_CODE_MAX, "time range")
    `LMFE_ASSERT_NXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(held), "hold lost")

endmodule

bind location_message_field_encoder_core lmfe_checker u_lmfe_checker (.*);
